// ===== hdl/elmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elmh_pkg
// Shared types, operation codes and the logistic table generator for the
// hidden-sigmoid network inference block.
// ----------------------------------------------------------------------------
package elmh_pkg;

    // Request operation codes
    localparam logic [1:0] OP_WR_IN_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_WR_OUT_WEIGHT = 2'd1;
    localparam logic [1:0] OP_FEATURE       = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_INPUTS  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN  = 2'd1;
    localparam logic [1:0] CFG_OUTPUTS = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 48;     // covers every parameter range
    localparam int ACT_W      = 13;     // activation 0..4096
    localparam logic [ACT_W-1:0] Q12_ONE = 13'd4096;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         weight_row;
        logic [5:0]         weight_col;
        logic signed [15:0] value;
        logic               last;
    } t_req;

    typedef struct packed {
        logic [2:0]         output_index;
        logic signed [31:0] output_value;
        logic               output_last;
    } t_result;

    // Shift-subtract division, elaboration use only
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | longint'(a[i]);
            if (r >= b) begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic value at the center of table bin k of n, Q.12
    function automatic logic [ACT_W-1:0] sig_entry(int k, int n);
        longint          c;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned term;
        longint unsigned g;
        longint unsigned e;
        longint unsigned s;
        c = longint'(udiv(longint'(2 * k + 1) << 27, longint'(n))) - (longint'(8) << 24);
        mag = (c < 0) ? longint'(-c) : longint'(c);
        u = mag << 3;
        term = longint'(1) << 30;
        g = term;
        for (int i = 1; i <= 20; i++) begin
            term = udiv((term * u) >> 30, longint'(i));
            g = g + term;
        end
        e = g >> 10;
        for (int i = 0; i < 3; i++) begin
            e = (e * e) >> 20;
        end
        s = udiv((e << 12) + udiv(e + (longint'(1) << 20), 2),
                 e + (longint'(1) << 20));
        if (c < 0) begin
            s = 4096 - s;
        end
        return ACT_W'(s);
    endfunction

endpackage

// ===== hdl/elmh_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elmh_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// A done pulse carries the finished sum and its tag.
// ----------------------------------------------------------------------------
module elmh_mac #(
    parameter int TAG_W = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_first,
    input  logic                      i_last,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic signed [16:0]        i_a,
    input  logic signed [15:0]        i_b,
    output logic                      o_done,
    output logic [TAG_W-1:0]          o_tag,
    output logic signed [elmh_pkg::ACC_W-1:0] o_acc
);
    import elmh_pkg::*;

    logic                 r_pv, r_pfirst, r_plast;
    logic [TAG_W-1:0]     r_ptag;
    logic signed [32:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                 r_done;
    logic [TAG_W-1:0]     r_tag;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
        r_pfirst <= i_first;
        r_plast  <= i_last;
        r_ptag   <= i_tag;
        r_prod   <= 33'(i_a * i_b);
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_pv & r_plast;
        end
        if (r_pv) begin
            r_acc <= (r_pfirst ? '0 : r_acc) + ACC_W'(r_prod);
            r_tag <= r_ptag;
        end
    end

    assign o_done = r_done;
    assign o_tag  = r_tag;
    assign o_acc  = r_acc;
endmodule

// ===== hdl/elmh_sig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elmh_sig
// Logistic sigmoid by table: bin index from a Q.24 sum, then table read.
// Two register stages.
// ----------------------------------------------------------------------------
module elmh_sig #(
    parameter int TAG_W           = 6,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic signed [elmh_pkg::ACC_W-1:0] i_z,
    output logic                      o_valid,
    output logic [TAG_W-1:0]          o_tag,
    output logic [elmh_pkg::ACT_W-1:0] o_value
);
    import elmh_pkg::*;

    localparam int IX_W = $clog2(SIGMOID_ENTRIES);
    localparam int NS_W = $clog2(SIGMOID_ENTRIES + 1);

    logic [ACT_W-1:0]        w_tbl [SIGMOID_ENTRIES];
    logic signed [ACC_W-1:0] w_v;
    logic [28+NS_W-1:0]      w_scaled;
    logic [IX_W-1:0]         w_idx;
    logic                    r_iv;
    logic [TAG_W-1:0]        r_itag;
    logic [IX_W-1:0]         r_idx;
    logic                    r_ov;
    logic [TAG_W-1:0]        r_otag;
    logic [ACT_W-1:0]        r_val;

    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_tbl
        assign w_tbl[k] = sig_entry(k, SIGMOID_ENTRIES);
    end

    // bin index: (z + 8) * entries / 16, clamped
    always_comb begin
        w_v      = i_z + (ACC_W'(8) <<< 24);
        w_scaled = (28+NS_W)'(w_v[27:0]) * (28+NS_W)'(SIGMOID_ENTRIES);
        if (w_v < 0) begin
            w_idx = '0;
        end else if (w_v >= (ACC_W'(1) <<< 28)) begin
            w_idx = IX_W'(SIGMOID_ENTRIES - 1);
        end else begin
            w_idx = w_scaled[28 +: IX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_iv <= i_valid;
            r_ov <= r_iv;
        end
        r_itag <= i_tag;
        r_idx  <= w_idx;
        r_otag <= r_itag;
        r_val  <= w_tbl[r_idx];
    end

    assign o_valid = r_ov;
    assign o_tag   = r_otag;
    assign o_value = r_val;
endmodule

// ===== hdl/elm_hidden_sigmoid_inference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elm_hidden_sigmoid_inference
// Single-hidden-layer inference with one shared MAC under a sequencer.
// ----------------------------------------------------------------------------
// Weight writes and non-final feature elements are taken while busy stays low.
// A final feature element holds busy through MAC issue for the hidden and output
// sums, pipeline drain and result output on the single multiply-accumulate unit.
// One result per output sum, one cycle wide; no stall.
// Synchronous active-low reset clears control and restores register defaults.
module elm_hidden_sigmoid_inference #(
    parameter int MAX_INPUTS      = 16,
    parameter int MAX_HIDDEN      = 64,
    parameter int MAX_OUTPUTS     = 8,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  elmh_pkg::t_req            i_req,
    output logic                      o_result_valid,
    output elmh_pkg::t_result         o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [elmh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import elmh_pkg::*;

    localparam int NW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int JW    = $clog2(MAX_HIDDEN);
    localparam int KW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int TAG_W = (JW > KW) ? JW : KW;
    localparam int IU_W  = $clog2(MAX_INPUTS + 1);
    localparam int HU_W  = $clog2(MAX_HIDDEN + 1);
    localparam int OU_W  = $clog2(MAX_OUTPUTS + 1);
    localparam int IW_AW = $clog2(MAX_INPUTS * MAX_HIDDEN);
    localparam int OW_AW = $clog2(MAX_HIDDEN * MAX_OUTPUTS);
    localparam int Q_W   = ACC_W - 12;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HID    = 3'd1;
    localparam logic [2:0] S_HDRAIN = 3'd2;
    localparam logic [2:0] S_OUT    = 3'd3;
    localparam logic [2:0] S_ODRAIN = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [IU_W-1:0]       r_in_use;
    logic [HU_W-1:0]       r_hid_use;
    logic [OU_W-1:0]       r_out_use;
    logic [IU_W-1:0]       r_count, r_used;
    logic signed [15:0]    r_fbuf [MAX_INPUTS];
    logic [NW-1:0]         r_n;
    logic [JW-1:0]         r_j;
    logic [KW-1:0]         r_k;
    logic [3:0]            r_wait;

    logic signed [15:0]    r_iw_mem [MAX_INPUTS*MAX_HIDDEN];
    logic signed [15:0]    r_ow_mem [MAX_HIDDEN*MAX_OUTPUTS];
    logic [ACT_W-1:0]      r_hid_mem [MAX_HIDDEN];
    logic signed [15:0]    r_iw_q, r_ow_q;
    logic [ACT_W-1:0]      r_hid_q;

    logic                  r_i1_v, r_i1_first, r_i1_last, r_i1_bias, r_i1_out;
    logic [TAG_W-1:0]      r_i1_tag;
    logic [NW-1:0]         r_i1_n;

    logic                  w_acc_req, w_feat, w_issue;
    logic                  w_n_end, w_j_end, w_k_end;
    logic                  w_iw_we, w_ow_we;
    logic [IW_AW-1:0]      w_iw_wa, w_iw_ra;
    logic [OW_AW-1:0]      w_ow_wa, w_ow_ra;
    logic [IU_W-1:0]       w_count_inc;
    logic signed [16:0]    w_a;
    logic signed [15:0]    w_b;
    logic                  w_mac_done;
    logic [TAG_W-1:0]      w_mac_tag;
    logic signed [ACC_W-1:0] w_mac_acc;
    logic                  w_sig_v;
    logic [TAG_W-1:0]      w_sig_tag;
    logic [ACT_W-1:0]      w_sig_val;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [Q_W-1:0] w_q;
    logic signed [31:0]    w_sat;
    logic                  w_out_done;
    logic                  r_out_v;
    t_result               r_out;

    assign w_acc_req   = start & ~busy;
    assign w_feat      = w_acc_req && (i_req.op == OP_FEATURE);
    assign w_count_inc = (r_count < r_in_use) ? r_count + 1'b1 : r_count;
    assign o_cfg_ready = 1'b1;

    // configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= IU_W'(MAX_INPUTS);
            r_hid_use <= HU_W'(MAX_HIDDEN);
            r_out_use <= OU_W'(MAX_OUTPUTS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INPUTS: begin
                    if (i_cfg_data < 1) r_in_use <= IU_W'(1);
                    else if (32'(i_cfg_data) > MAX_INPUTS) r_in_use <= IU_W'(MAX_INPUTS);
                    else r_in_use <= IU_W'(i_cfg_data);
                end
                CFG_HIDDEN: begin
                    if (i_cfg_data < 2) r_hid_use <= HU_W'(2);
                    else if (32'(i_cfg_data) > MAX_HIDDEN) r_hid_use <= HU_W'(MAX_HIDDEN);
                    else r_hid_use <= HU_W'(i_cfg_data);
                end
                CFG_OUTPUTS: begin
                    if (i_cfg_data < 1) r_out_use <= OU_W'(1);
                    else if (32'(i_cfg_data) > MAX_OUTPUTS) r_out_use <= OU_W'(MAX_OUTPUTS);
                    else r_out_use <= OU_W'(i_cfg_data);
                end
                default: ;
            endcase
        end
    end

    // weight store write decode
    assign w_iw_we = w_acc_req && (i_req.op == OP_WR_IN_WEIGHT)
                     && (32'(i_req.weight_row) < MAX_INPUTS)
                     && (32'(i_req.weight_col) < MAX_HIDDEN);
    assign w_ow_we = w_acc_req && (i_req.op == OP_WR_OUT_WEIGHT)
                     && (32'(i_req.weight_row) < MAX_HIDDEN)
                     && (32'(i_req.weight_col) < MAX_OUTPUTS);
    assign w_iw_wa = IW_AW'(32'(i_req.weight_row) * MAX_HIDDEN + 32'(i_req.weight_col));
    assign w_ow_wa = OW_AW'(32'(i_req.weight_row) * MAX_OUTPUTS + 32'(i_req.weight_col));
    assign w_iw_ra = IW_AW'(32'(r_n) * MAX_HIDDEN + 32'(r_j));
    assign w_ow_ra = OW_AW'(32'(r_j) * MAX_OUTPUTS + 32'(r_k));

    // memories
    always_ff @(posedge i_clk) begin
        if (w_iw_we) r_iw_mem[w_iw_wa] <= i_req.value;
        r_iw_q <= r_iw_mem[w_iw_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_ow_we) r_ow_mem[w_ow_wa] <= i_req.value;
        r_ow_q <= r_ow_mem[w_ow_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_sig_v) r_hid_mem[JW'(w_sig_tag)] <= w_sig_val;
        r_hid_q <= r_hid_mem[r_j];
    end

    // feature buffer
    always_ff @(posedge i_clk) begin
        if (w_feat && r_count < r_in_use) begin
            r_fbuf[NW'(r_count)] <= i_req.value;
        end
    end

    // sequence ends
    assign w_n_end = (32'(r_n) + 1 == 32'(r_used));
    assign w_j_end = (r_state == S_HID) ? (32'(r_j) + 2 == 32'(r_hid_use))
                                        : (32'(r_j) + 1 == 32'(r_hid_use));
    assign w_k_end = (32'(r_k) + 1 == 32'(r_out_use));
    assign w_issue = (r_state == S_HID) || (r_state == S_OUT);
    assign w_out_done = w_mac_done && r_state == S_ODRAIN;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_feat && i_req.last) n_state = S_HID;
            S_HID:    if (w_n_end && w_j_end) n_state = S_HDRAIN;
            S_HDRAIN: if (r_wait == 4'd9) n_state = S_OUT;
            S_OUT:    if (w_j_end && w_k_end) n_state = S_ODRAIN;
            S_ODRAIN: if (w_out_done && 32'(w_mac_tag) + 1 == 32'(r_out_use)) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_used  <= '0;
            r_n     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            if (w_feat) begin
                r_count <= i_req.last ? '0 : w_count_inc;
                if (i_req.last) r_used <= w_count_inc;
            end
            r_n <= '0;
            unique case (r_state)
                S_IDLE: begin
                    r_j <= '0;
                    r_k <= '0;
                end
                S_HID: begin
                    if (w_n_end) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                    r_wait <= '0;
                end
                S_HDRAIN: begin
                    r_wait <= r_wait + 1'b1;
                    r_j    <= '0;
                    r_k    <= '0;
                end
                S_OUT: begin
                    if (w_j_end) begin
                        r_j <= '0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // issue stage, aligned with memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i1_v <= 1'b0;
        end else begin
            r_i1_v <= w_issue;
        end
        r_i1_out <= (r_state == S_OUT);
        r_i1_n   <= r_n;
        if (r_state == S_HID) begin
            r_i1_first <= (r_n == '0);
            r_i1_last  <= w_n_end;
            r_i1_tag   <= TAG_W'(r_j);
            r_i1_bias  <= 1'b0;
        end else begin
            r_i1_first <= (r_j == '0);
            r_i1_last  <= w_j_end;
            r_i1_tag   <= TAG_W'(r_k);
            r_i1_bias  <= w_j_end;
        end
    end

    // operand select
    always_comb begin
        if (r_i1_out) begin
            w_a = r_i1_bias ? 17'(Q12_ONE) : 17'(r_hid_q);
            w_b = r_ow_q;
        end else begin
            w_a = 17'(r_fbuf[r_i1_n]);
            w_b = r_iw_q;
        end
    end

    elmh_mac #(.TAG_W(TAG_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_i1_v),
        .i_first (r_i1_first),
        .i_last  (r_i1_last),
        .i_tag   (r_i1_tag),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mac_done),
        .o_tag   (w_mac_tag),
        .o_acc   (w_mac_acc)
    );

    elmh_sig #(.TAG_W(TAG_W), .SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_sig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mac_done && (r_state == S_HID || r_state == S_HDRAIN)),
        .i_tag   (w_mac_tag),
        .i_z     (w_mac_acc),
        .o_valid (w_sig_v),
        .o_tag   (w_sig_tag),
        .o_value (w_sig_val)
    );

    // round to Q.12 and saturate
    always_comb begin
        w_rnd = w_mac_acc + ACC_W'(2048);
        w_q   = Q_W'(w_rnd >>> 12);
        if (w_q > Q_W'(32'sh7fffffff)) w_sat = 32'sh7fffffff;
        else if (w_q < -Q_W'(33'sh80000000)) w_sat = 32'sh80000000;
        else w_sat = 32'(w_q);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_mac_done && (r_state == S_OUT || r_state == S_ODRAIN);
        end
        r_out.output_index <= 3'(w_mac_tag);
        r_out.output_value <= w_sat;
        r_out.output_last  <= (32'(w_mac_tag) + 1 == 32'(r_out_use));
    end

    assign busy           = (r_state != S_IDLE) || r_out_v;
    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state != S_IDLE) |-> $past(w_feat && i_req.last))
        else $error("sequencer left idle without a final feature");
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result outside of busy window");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.output_last) |=> !busy)
        else $error("busy held after final result");
    a_no_sig_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !w_sig_v)
        else $error("hidden write during output phase");
`endif
endmodule
